// ===== rtl/core/pgem_pkg.sv =====
// ----------------------------------------------------------------------------
// pgem_pkg
// Types and constants shared by the pixel gradient energy map files.
// ----------------------------------------------------------------------------
package pgem_pkg;

    localparam int CFG_W          = 11;
    localparam int CFG_IDX_W      = 1;
    localparam int SIZE_RESET     = 1024;

    localparam int CHAN_W         = 8;
    localparam int ENERGY_W       = 7;
    localparam int COORD_W        = 10;

    // Neighbor positions within an operand word.
    localparam int NBR_COUNT      = 4;
    localparam int NBR_UP         = 0;
    localparam int NBR_DOWN       = 1;
    localparam int NBR_LEFT       = 2;
    localparam int NBR_RIGHT      = 3;

    // Kinds of result one pixel can finish, in delivery order.
    localparam int RES_KINDS      = 3;
    localparam int RES_ABOVE      = 0;
    localparam int RES_LEFT       = 1;
    localparam int RES_SELF       = 2;

    // floor(x / 3) == (x * 683) >> 11 for every x below 2048.
    localparam int DIV3_MUL       = 683;
    localparam int DIV3_SHIFT     = 11;

    localparam int OUT_FIFO_DEPTH = 8;
    localparam int OUT_FIFO_AW    = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_column;
        logic [COORD_W-1:0] pixel_row;
        logic               last_of_item;
        logic               frame_done;
    } t_tag;

    typedef struct packed {
        t_pixel                  center;
        t_pixel [NBR_COUNT-1:0]  nbr;
        logic   [NBR_COUNT-1:0]  present;
        t_tag                    tag;
    } t_operands;

    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic [COORD_W-1:0]  pixel_column;
        logic [COORD_W-1:0]  pixel_row;
        logic                last_of_item;
        logic                frame_done;
    } t_result;

endpackage

// ===== rtl/core/pgem_stream_if.sv =====
// ----------------------------------------------------------------------------
// pgem_stream_if
// Valid/ready stream channel carrying one payload word per handshake.
// ----------------------------------------------------------------------------
interface pgem_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/pixel_gradient_energy_map.sv =====
// ----------------------------------------------------------------------------
// pixel_gradient_energy_map
// Streaming gradient energy of an RGB frame in raster order, with three
// rotating row stores in one RAM.
//
//   channel    dir  word                              handshake
//   i_pixel    in   red, green, blue                  valid/ready
//   o_energy   out  energy, pixel_column, pixel_row,  valid/ready
//                   last_of_item, frame_done
//   i_cfg_*    in   image_width (0), image_height (1) write enable
//
// Outside the last row a pixel finishes at most one pixel, in the last row up to
// two (three at the row end), one per cycle from the single issue stage while the
// output queue has room; the next pixel is taken as the last one issues. Reset
// clears counters and queues and sets both sizes to 1024; the row RAM needs no
// clearing. An eight-word output queue lets pixels keep coming while results wait.
// ----------------------------------------------------------------------------
module pixel_gradient_energy_map
    import pgem_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    pgem_stream_if.sink          i_pixel,
    pgem_stream_if.source        o_energy
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int DEPTH = 3 * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int MW    = (CW > RW) ? CW : RW;
    localparam int CMPW  = ((MW > CFG_W) ? MW : CFG_W) + 1;
    localparam int PIX_W = $bits(t_pixel);
    localparam int RSV_W = $clog2(OUT_FIFO_DEPTH + 1);

    function automatic logic [AW-1:0] row_addr(input logic [1:0]    slot,
                                               input logic [CW-1:0] col);
        logic [AW-1:0] base;
        case (slot)
            2'd1:    base = AW'(MAX_WIDTH);
            2'd2:    base = AW'(2 * MAX_WIDTH);
            default: base = '0;
        endcase
        return base + AW'(col);
    endfunction

    // Configuration.
    logic [CFG_W-1:0] r_image_width;
    logic [CFG_W-1:0] r_image_height;
    logic [CMPW-1:0]  w_eff;
    logic [CMPW-1:0]  h_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= CFG_W'(SIZE_RESET);
            r_image_height <= CFG_W'(SIZE_RESET);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
            endcase
        end
    end

    always_comb begin
        if (r_image_width == '0) begin
            w_eff = CMPW'(1);
        end else if (CMPW'(r_image_width) > CMPW'(MAX_WIDTH)) begin
            w_eff = CMPW'(MAX_WIDTH);
        end else begin
            w_eff = CMPW'(r_image_width);
        end
        if (r_image_height == '0) begin
            h_eff = CMPW'(1);
        end else if (CMPW'(r_image_height) > CMPW'(MAX_HEIGHT)) begin
            h_eff = CMPW'(MAX_HEIGHT);
        end else begin
            h_eff = CMPW'(r_image_height);
        end
    end

    // Raster position of the next pixel.
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [1:0]    r_slot;
    logic [1:0]    slot_prev;
    logic [1:0]    slot_prev2;
    logic [CW-1:0] col_next;
    logic [CMPW-1:0] col_x;
    logic [CMPW-1:0] row_x;
    logic          last_row;
    logic          row_end;
    logic          accept;
    t_pixel        pix_in;

    assign pix_in     = i_pixel.payload;
    assign col_x      = CMPW'(r_col);
    assign row_x      = CMPW'(r_row);
    assign last_row   = (row_x + CMPW'(1)) >= h_eff;
    assign row_end    = (col_x + CMPW'(1)) >= w_eff;
    assign slot_prev  = (r_slot == 2'd0) ? 2'd2 : r_slot - 2'd1;
    assign slot_prev2 = (r_slot == 2'd2) ? 2'd0 : r_slot + 2'd1;
    assign col_next   = (r_col == CW'(MAX_WIDTH - 1)) ? '0 : r_col + CW'(1);
    assign accept     = i_pixel.valid && i_pixel.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= 2'd0;
        end else if (accept) begin
            if (row_end) begin
                r_col <= '0;
                if (last_row) begin
                    r_row  <= '0;
                    r_slot <= 2'd0;
                end else begin
                    r_row  <= r_row + RW'(1);
                    r_slot <= slot_prev2;
                end
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // Row store. Port A fetches the row two back at this column, port B the
    // previous row one column ahead. The write always goes to the current
    // row's slot, so reads and the write never meet on one entry.
    logic [PIX_W-1:0] rd_prev2;
    logic [PIX_W-1:0] rd_prev_next;

    pgem_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_row_store (
        .i_clk     (i_clk),
        .i_we      (accept),
        .i_waddr   (row_addr(r_slot, r_col)),
        .i_wdata   (pix_in),
        .i_re      (accept),
        .i_raddr_a (row_addr(slot_prev2, r_col)),
        .i_raddr_b (row_addr(slot_prev, col_next)),
        .o_rdata_a (rd_prev2),
        .o_rdata_b (rd_prev_next)
    );

    // Issue stage: one pixel, one result a cycle to the energy pipeline while the queue has room.
    logic                 r_b_valid;
    logic [RES_KINDS-1:0] r_b_pend;
    t_pixel               r_b_pix;
    logic [CW-1:0]        r_b_col;
    logic [RW-1:0]        r_b_row;
    logic                 r_b_row_gt0;
    logic                 r_b_row_gt1;
    logic                 r_b_row_lt_h;
    logic                 r_b_col_gt0;
    logic                 r_b_col_gt1;
    logic                 r_b_col_lt_w;
    logic                 r_b_right;
    logic                 r_b_row_end;

    // Sliding windows: previous row at columns c-1 and c, current row at c-2
    // and c-1, and the first pixel of the current row.
    t_pixel r_pm1;
    t_pixel r_p0;
    t_pixel r_cm2;
    t_pixel r_cm1;
    t_pixel r_first;

    logic [RES_KINDS-1:0] acc_pend;
    logic [RES_KINDS-1:0] n_pend;
    logic                 b_single;
    logic                 credit_ok;
    logic                 issue;
    logic                 b_finish;
    t_operands            op;
    logic [CMPW-1:0]      b_col_x;
    logic [CMPW-1:0]      b_row_x;
    logic [CMPW-1:0]      b_colm1_x;
    logic [CMPW-1:0]      b_rowm1_x;

    assign acc_pend[RES_ABOVE] = (r_row != '0);
    assign acc_pend[RES_LEFT]  = last_row && (r_col != '0);
    assign acc_pend[RES_SELF]  = last_row && row_end;

    assign n_pend   = r_b_pend & (r_b_pend - RES_KINDS'(1));
    assign b_single = (n_pend == '0);
    assign issue    = r_b_valid && (r_b_pend != '0) && credit_ok;
    assign b_finish = r_b_valid && ((r_b_pend == '0) || (issue && b_single));

    assign i_pixel.ready = !r_b_valid || b_finish;

    assign b_col_x   = CMPW'(r_b_col);
    assign b_row_x   = CMPW'(r_b_row);
    assign b_colm1_x = b_col_x - CMPW'(1);
    assign b_rowm1_x = b_row_x - CMPW'(1);

    always_comb begin
        op                  = '0;
        op.tag.last_of_item = b_single;
        if (r_b_pend[RES_ABOVE]) begin
            // The pixel above: its lower neighbor is the arriving pixel.
            op.center             = r_p0;
            op.nbr[NBR_UP]        = rd_prev2;
            op.present[NBR_UP]    = r_b_row_gt1;
            op.nbr[NBR_DOWN]      = r_b_pix;
            op.present[NBR_DOWN]  = r_b_row_lt_h;
            op.nbr[NBR_LEFT]      = r_pm1;
            op.present[NBR_LEFT]  = r_b_col_gt0;
            op.nbr[NBR_RIGHT]     = rd_prev_next;
            op.present[NBR_RIGHT] = r_b_right;
            op.tag.pixel_column   = b_col_x[COORD_W-1:0];
            op.tag.pixel_row      = b_rowm1_x[COORD_W-1:0];
        end else if (r_b_pend[RES_LEFT]) begin
            // Left neighbor in the last row; it has no lower neighbor.
            op.center             = r_cm1;
            op.nbr[NBR_UP]        = r_pm1;
            op.present[NBR_UP]    = r_b_row_gt0;
            op.nbr[NBR_LEFT]      = r_cm2;
            op.present[NBR_LEFT]  = r_b_col_gt1;
            op.nbr[NBR_RIGHT]     = r_b_pix;
            op.present[NBR_RIGHT] = r_b_col_lt_w;
            op.tag.pixel_column   = b_colm1_x[COORD_W-1:0];
            op.tag.pixel_row      = b_row_x[COORD_W-1:0];
        end else begin
            // Bottom right pixel finishes itself.
            op.center             = r_b_pix;
            op.nbr[NBR_UP]        = r_p0;
            op.present[NBR_UP]    = r_b_row_gt0;
            op.nbr[NBR_LEFT]      = r_cm1;
            op.present[NBR_LEFT]  = r_b_col_gt0;
            op.tag.pixel_column   = b_col_x[COORD_W-1:0];
            op.tag.pixel_row      = b_row_x[COORD_W-1:0];
            op.tag.frame_done     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_b_pend  <= '0;
        end else if (accept) begin
            r_b_valid <= 1'b1;
            r_b_pend  <= acc_pend;
        end else if (b_finish) begin
            r_b_valid <= 1'b0;
            r_b_pend  <= '0;
        end else if (issue) begin
            r_b_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_pix      <= pix_in;
            r_b_col      <= r_col;
            r_b_row      <= r_row;
            r_b_row_gt0  <= (r_row != '0);
            r_b_row_gt1  <= row_x > CMPW'(1);
            r_b_row_lt_h <= row_x < h_eff;
            r_b_col_gt0  <= (r_col != '0);
            r_b_col_gt1  <= col_x > CMPW'(1);
            r_b_col_lt_w <= col_x < w_eff;
            r_b_right    <= !row_end;
            r_b_row_end  <= row_end;
        end
        if (b_finish) begin
            r_pm1 <= r_p0;
            if (r_b_row_end) begin
                // The row just closed becomes the previous row.
                r_p0 <= (r_b_col == '0) ? r_b_pix : r_first;
            end else begin
                r_p0 <= rd_prev_next;
            end
            r_cm2 <= r_cm1;
            r_cm1 <= r_b_pix;
            if (r_b_col == '0) begin
                r_first <= r_b_pix;
            end
        end
    end

    // Energy arithmetic.
    logic    e_valid;
    t_result e_result;

    pgem_energy u_energy (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (issue),
        .i_op     (op),
        .o_valid  (e_valid),
        .o_result (e_result)
    );

    // Output queue. Every issued result reserves a slot, so the queue never
    // overflows and the pipeline never stalls.
    t_result            r_fifo [OUT_FIFO_DEPTH];
    logic [OUT_FIFO_AW:0] r_wptr;
    logic [OUT_FIFO_AW:0] r_rptr;
    logic [RSV_W-1:0]   r_reserved;
    logic [RSV_W-1:0]   n_reserved;
    logic               pop;

    assign o_energy.valid   = (r_wptr != r_rptr);
    assign o_energy.payload = r_fifo[r_rptr[OUT_FIFO_AW-1:0]];
    assign pop              = o_energy.valid && o_energy.ready;
    assign credit_ok        = r_reserved < RSV_W'(OUT_FIFO_DEPTH);

    always_comb begin
        n_reserved = r_reserved;
        if (issue && !pop) begin
            n_reserved = r_reserved + RSV_W'(1);
        end else if (pop && !issue) begin
            n_reserved = r_reserved - RSV_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr     <= '0;
            r_rptr     <= '0;
            r_reserved <= '0;
        end else begin
            r_reserved <= n_reserved;
            if (e_valid) begin
                r_wptr <= r_wptr + (OUT_FIFO_AW + 1)'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + (OUT_FIFO_AW + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_valid) begin
            r_fifo[r_wptr[OUT_FIFO_AW-1:0]] <= e_result;
        end
    end

endmodule

// ===== rtl/core/pgem_ram.sv =====
// ----------------------------------------------------------------------------
// pgem_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module pgem_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 3072
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // Read data holds while no read is requested.
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== rtl/core/pgem_energy.sv =====
// ----------------------------------------------------------------------------
// pgem_energy
// Four-stage energy pipeline: operand register, per-neighbor difference
// terms, sum divided by three, division by the neighbor count.
// ----------------------------------------------------------------------------
module pgem_energy
    import pgem_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_operands i_op,
    output logic      o_valid,
    output t_result   o_result
);

    localparam int SAD_W   = 10;
    localparam int TERM_W  = 8;
    localparam int TOTAL_W = 10;
    localparam int Q_W     = 9;
    localparam int PROD_W  = 20;
    localparam int CNT_W   = 3;

    function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Stage 1: operands.
    logic      r_s1_valid;
    t_operands r_s1_op;

    // Stage 2: difference terms.
    logic              r_s2_valid;
    logic [TERM_W-1:0] r_s2_term [NBR_COUNT];
    logic [CNT_W-1:0]  r_s2_cnt;
    t_tag              r_s2_tag;

    // Stage 3: total divided by three.
    logic             r_s3_valid;
    logic [Q_W-1:0]   r_s3_q;
    logic [CNT_W-1:0] r_s3_cnt;
    t_tag             r_s3_tag;

    // Stage 4: result.
    logic    r_s4_valid;
    t_result r_s4_result;

    logic [SAD_W-1:0]   sad  [NBR_COUNT];
    logic [PROD_W-1:0]  prod [NBR_COUNT];
    logic [TERM_W-1:0]  term [NBR_COUNT];
    logic [TOTAL_W-1:0] total;
    logic [PROD_W-1:0]  total_prod;
    logic [PROD_W-1:0]  q_prod;
    logic [ENERGY_W-1:0] energy;

    always_comb begin
        for (int k = 0; k < NBR_COUNT; k++) begin
            sad[k] = SAD_W'(abs_diff(r_s1_op.center.red,   r_s1_op.nbr[k].red))
                   + SAD_W'(abs_diff(r_s1_op.center.green, r_s1_op.nbr[k].green))
                   + SAD_W'(abs_diff(r_s1_op.center.blue,  r_s1_op.nbr[k].blue));
            prod[k] = PROD_W'(sad[k]) * PROD_W'(DIV3_MUL);
            term[k] = r_s1_op.present[k] ? prod[k][DIV3_SHIFT+TERM_W-1:DIV3_SHIFT] : '0;
        end
    end

    always_comb begin
        total = '0;
        for (int k = 0; k < NBR_COUNT; k++) begin
            total = total + TOTAL_W'(r_s2_term[k]);
        end
        total_prod = PROD_W'(total) * PROD_W'(DIV3_MUL);
    end

    // The second division is by three times the count; the first factor of
    // three is already out, so only the count remains.
    assign q_prod = PROD_W'(r_s3_q) * PROD_W'(DIV3_MUL);

    always_comb begin
        case (r_s3_cnt)
            3'd1:    energy = r_s3_q[ENERGY_W-1:0];
            3'd2:    energy = r_s3_q[ENERGY_W:1];
            3'd3:    energy = q_prod[DIV3_SHIFT+ENERGY_W-1:DIV3_SHIFT];
            3'd4:    energy = r_s3_q[ENERGY_W+1:2];
            default: energy = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_op <= i_op;

        for (int k = 0; k < NBR_COUNT; k++) begin
            r_s2_term[k] <= term[k];
        end
        r_s2_cnt <= CNT_W'($countones(r_s1_op.present));
        r_s2_tag <= r_s1_op.tag;

        r_s3_q   <= total_prod[DIV3_SHIFT+Q_W-1:DIV3_SHIFT];
        r_s3_cnt <= r_s2_cnt;
        r_s3_tag <= r_s2_tag;

        r_s4_result.energy       <= energy;
        r_s4_result.pixel_column <= r_s3_tag.pixel_column;
        r_s4_result.pixel_row    <= r_s3_tag.pixel_row;
        r_s4_result.last_of_item <= r_s3_tag.last_of_item;
        r_s4_result.frame_done   <= r_s3_tag.frame_done;
    end

    assign o_valid  = r_s4_valid;
    assign o_result = r_s4_result;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pixel_gradient_energy_map. Frames of random and
// hand-picked pixels go in under several frame sizes; an in-bench line store
// model predicts the words no directed row lists, and all are compared field
// by field in arrival order. Source and sink pause at varying rates; in one
// phase the sink holds off long enough to back the block up to its input.
// ----------------------------------------------------------------------------
module testbench;
    import pgem_pkg::*;

    localparam int MAX_DIM       = 1024;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 66;

    typedef struct {
        bit               is_cfg;
        bit               set_w;
        bit               set_h;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        t_pixel           px;
        int               n_typed;
        t_result [1:0]    typed;
    } t_dir_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;

    pgem_stream_if #(.t_payload(t_pixel))  pix_if ();
    pgem_stream_if #(.t_payload(t_result)) egy_if ();

    pixel_gradient_energy_map #(
        .MAX_WIDTH  (MAX_DIM),
        .MAX_HEIGHT (MAX_DIM)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pixel     (pix_if),
        .o_energy    (egy_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Line store model and frame position.
    t_pixel           line_buf [3*MAX_DIM];
    int unsigned      next_col;
    int unsigned      next_row;
    int unsigned      cur_slot;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    t_result     finished_now [$];
    t_result     energy_expected [$];
    int unsigned mismatch_count;
    int unsigned src_idle_pct;
    int unsigned snk_stall_pct;
    bit          hold_req;
    int unsigned cycle_count;
    t_dir_row    dir_rows [$];

    function automatic t_result make_energy(int unsigned e, int unsigned c, int unsigned r,
                                            bit last, bit done);
        t_result res;
        res.energy       = ENERGY_W'(e);
        res.pixel_column = COORD_W'(c);
        res.pixel_row    = COORD_W'(r);
        res.last_of_item = last;
        res.frame_done   = done;
        return res;
    endfunction

    function automatic int unsigned eff_size(logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    function automatic int unsigned chan_diff(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
        return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    function automatic int unsigned rgb_distance(t_pixel a, t_pixel b);
        return (chan_diff(a.red, b.red) + chan_diff(a.green, b.green)
                + chan_diff(a.blue, b.blue)) / 3;
    endfunction

    function automatic int unsigned gradient_energy(int unsigned c, int unsigned r,
                                                    int unsigned s_mid, int unsigned s_up,
                                                    int unsigned s_dn, int unsigned w,
                                                    int unsigned h);
        t_pixel      mid;
        int unsigned sum;
        int unsigned n;
        mid = line_buf[s_mid*MAX_DIM + c];
        sum = 0;
        n   = 0;
        if (r > 0) begin
            sum += rgb_distance(mid, line_buf[s_up*MAX_DIM + c]);
            n++;
        end
        if (r + 1 < h) begin
            sum += rgb_distance(mid, line_buf[s_dn*MAX_DIM + c]);
            n++;
        end
        if (c > 0) begin
            sum += rgb_distance(line_buf[s_mid*MAX_DIM + c - 1], mid);
            n++;
        end
        if (c + 1 < w) begin
            sum += rgb_distance(mid, line_buf[s_mid*MAX_DIM + c + 1]);
            n++;
        end
        if (n == 0) return 0;
        // The total is divided by three times the neighbor count on purpose.
        return sum / (3 * n);
    endfunction

    // Stores the pixel and leaves the energies it finishes in finished_now.
    task automatic predict_pixel(input t_pixel px);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned prev;
        int unsigned prev2;
        bit          last_row;
        bit          row_end;
        t_result     tail;
        w        = eff_size(width_reg);
        h        = eff_size(height_reg);
        c        = next_col;
        r        = next_row;
        prev     = (cur_slot + 2) % 3;
        prev2    = (cur_slot + 1) % 3;
        last_row = (r + 1 >= h);
        row_end  = (c + 1 >= w);
        line_buf[cur_slot*MAX_DIM + c] = px;
        finished_now.delete();
        if (r > 0)
            finished_now.push_back(make_energy(
                gradient_energy(c, r - 1, prev, prev2, cur_slot, w, h), c, r - 1, 0, 0));
        if (last_row && c > 0)
            finished_now.push_back(make_energy(
                gradient_energy(c - 1, r, cur_slot, prev, cur_slot, w, h), c - 1, r, 0, 0));
        if (last_row && row_end)
            finished_now.push_back(make_energy(
                gradient_energy(c, r, cur_slot, prev, cur_slot, w, h), c, r, 0, 1));
        if (finished_now.size() > 0) begin
            tail = finished_now.pop_back();
            tail.last_of_item = 1'b1;
            finished_now.push_back(tail);
        end
        if (row_end) begin
            next_col = 0;
            if (last_row) begin
                next_row = 0;
                cur_slot = 0;
            end else begin
                next_row = r + 1;
                cur_slot = (cur_slot + 1) % 3;
            end
        end else begin
            next_col = c + 1;
        end
    endtask

    // Offers one word and queues its energies once the block takes it.
    task automatic send_pixel(input t_pixel px);
        if ($urandom_range(99) < src_idle_pct) begin
            pix_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        pix_if.valid   <= 1'b1;
        pix_if.payload <= px;
        do @(posedge i_clk); while (!pix_if.ready);
        foreach (finished_now[k]) energy_expected.push_back(finished_now[k]);
    endtask

    function automatic logic [CHAN_W-1:0] random_chan();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return CHAN_W'($urandom_range(255));
        endcase
    endfunction

    task automatic stream_random_pixel();
        t_pixel px;
        px.red   = random_chan();
        px.green = random_chan();
        px.blue  = random_chan();
        predict_pixel(px);
        send_pixel(px);
    endtask

    task automatic finish_frame();
        while (next_col != 0 || next_row != 0) stream_random_pixel();
    endtask

    // Completes the frame, lets the block drain, then writes the size registers.
    task automatic program_size(input bit set_w, input bit set_h,
                                input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        finish_frame();
        pix_if.valid <= 1'b0;
        while (energy_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (set_w) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= REG_IMAGE_WIDTH;
            i_cfg_data  <= w;
            width_reg    = w;
            @(posedge i_clk);
        end
        if (set_h) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= REG_IMAGE_HEIGHT;
            i_cfg_data  <= h;
            height_reg   = h;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] random_size(int unsigned typical_max);
        case ($urandom_range(9))
            0: return '0;
            1: return CFG_W'(1);
            2: return CFG_W'($urandom_range(12, 24));
            default: return CFG_W'($urandom_range(2, typical_max));
        endcase
    endfunction

    function automatic t_dir_row cfg_row(bit set_w, bit set_h, int w, int h);
        t_dir_row row;
        row         = '{default: '0};
        row.is_cfg  = 1'b1;
        row.set_w   = set_w;
        row.set_h   = set_h;
        row.w       = CFG_W'(w);
        row.h       = CFG_W'(h);
        return row;
    endfunction

    // n_typed below zero leaves the row to the line store model.
    function automatic t_dir_row pix_row(int red, int green, int blue, int n_typed,
                                         t_result first = '0, t_result second = '0);
        t_dir_row row;
        row          = '{default: '0};
        row.px.red   = CHAN_W'(red);
        row.px.green = CHAN_W'(green);
        row.px.blue  = CHAN_W'(blue);
        row.n_typed  = n_typed;
        row.typed[0] = first;
        row.typed[1] = second;
        return row;
    endfunction

    task automatic check_energy(input t_result got);
        t_result want;
        if (energy_expected.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("Unexpected energy word: energy %0d col %0d row %0d last %b done %b",
                         got.energy, got.pixel_column, got.pixel_row, got.last_of_item,
                         got.frame_done);
            return;
        end
        want = energy_expected.pop_front();
        if (got.energy !== want.energy || got.pixel_column !== want.pixel_column
                || got.pixel_row !== want.pixel_row || got.last_of_item !== want.last_of_item
                || got.frame_done !== want.frame_done) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("Energy mismatch: expected %0d/%0d/%0d/%b/%b, got %0d/%0d/%0d/%b/%b",
                         want.energy, want.pixel_column, want.pixel_row, want.last_of_item,
                         want.frame_done, got.energy, got.pixel_column, got.pixel_row,
                         got.last_of_item, got.frame_done);
        end
    endtask

    // Energy sink: checks accepted words and decides ready for the next cycle.
    initial begin : energy_sink
        int unsigned hold_left;
        hold_left     = 0;
        egy_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && egy_if.valid && egy_if.ready) check_energy(egy_if.payload);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                egy_if.ready <= 1'b0;
            end else begin
                egy_if.ready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned phase_items;
        cycle_count    = 0;
        mismatch_count = 0;
        src_idle_pct   = 0;
        snk_stall_pct  = 0;
        hold_req       = 1'b0;
        next_col       = 0;
        next_row       = 0;
        cur_slot       = 0;
        width_reg      = CFG_W'(SIZE_RESET);
        height_reg     = CFG_W'(SIZE_RESET);
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= REG_IMAGE_WIDTH;
        i_cfg_data     <= '0;
        pix_if.valid   <= 1'b0;
        pix_if.payload <= '0;

        dir_rows = '{
            // One column, height left at its reset value.
            cfg_row(1, 0, 1, 0),
            pix_row(0, 0, 0, 0),
            pix_row(255, 255, 255, 1, make_energy(85, 0, 0, 1, 0)),
            pix_row(8'h0F, 8'hF0, 8'h55, -1),
            pix_row(8'hAA, 8'h55, 8'hFF, -1),
            // Zero sizes act as one: a single pixel has no neighbor.
            cfg_row(1, 1, 0, 0),
            pix_row(255, 0, 128, 1, make_energy(0, 0, 0, 1, 1)),
            pix_row(0, 255, 0, 1, make_energy(0, 0, 0, 1, 1)),
            cfg_row(1, 1, 2, 1),
            pix_row(0, 0, 0, 0),
            pix_row(255, 255, 255, 2, make_energy(85, 0, 0, 0, 0),
                    make_energy(85, 1, 0, 1, 1)),
            // Three by three with a white center that sees all four neighbors.
            cfg_row(1, 1, 3, 3),
            pix_row(0, 0, 0, -1),
            pix_row(0, 0, 0, -1),
            pix_row(0, 0, 0, -1),
            pix_row(0, 0, 0, -1),
            pix_row(255, 255, 255, -1),
            pix_row(0, 0, 0, -1),
            pix_row(0, 0, 0, -1),
            pix_row(0, 0, 0, 2, make_energy(85, 1, 1, 0, 0), make_energy(0, 0, 2, 1, 0)),
            pix_row(0, 0, 0, -1),
            // Oversized registers saturate at the maximum frame size.
            cfg_row(1, 1, 2047, 1),
            pix_row(255, 255, 255, 0),
            pix_row(0, 0, 0, 1, make_energy(85, 0, 0, 1, 0)),
            cfg_row(1, 1, 0, 2047),
            pix_row(255, 255, 255, 0),
            pix_row(0, 0, 0, 1, make_energy(85, 0, 0, 1, 0))
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                program_size(dir_rows[i].set_w, dir_rows[i].set_h, dir_rows[i].w,
                             dir_rows[i].h);
            end else begin
                predict_pixel(dir_rows[i].px);
                if (dir_rows[i].n_typed >= 0) begin
                    finished_now.delete();
                    for (int k = 0; k < dir_rows[i].n_typed; k++)
                        finished_now.push_back(dir_rows[i].typed[k]);
                end
                send_pixel(dir_rows[i].px);
            end
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            program_size(1, 1, random_size(9), random_size(6));
            case (ph)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 87; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 87; end
                3: begin src_idle_pct = 23; snk_stall_pct = 23; end
                default: begin
                    // The sink stops for a long while and the output queue fills.
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                    hold_req      = 1'b1;
                end
            endcase
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                if (phase_items != 0 && $urandom_range(1))
                    program_size(1, 1, random_size(9), random_size(6));
                do begin
                    stream_random_pixel();
                    phase_items++;
                end while (next_col != 0 || next_row != 0);
            end
        end

        pix_if.valid <= 1'b0;
        while (energy_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && energy_expected.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
